// ----- design/crp_pkg.sv -----
// Shared types, codes and constants of the clock page replacer.
`default_nettype none

package crp_pkg;

   localparam int MAX_FRAMES_DEF = 64;
   localparam int FRAMES_REG_W   = 7;
   localparam int FRAMES_RESET   = 64;

   localparam int                LIMIT_W     = 8;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd20;

   // request operation codes
   localparam int             MODE_W      = 2;
   localparam logic [MODE_W-1:0] MODE_PIN    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_UNPIN  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_VICTIM = 2'd2;

   // register indexes on the csr port
   localparam int                   CSR_ADDR_W        = 1;
   localparam logic [CSR_ADDR_W-1:0] CSR_FRAMES_IN_USE = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_SEARCH_LIMIT  = 1'b1;

   localparam int QUEUE_DEPTH = 2;

   // frame status codes; code three is never written and reads as pinned
   localparam int                 STATUS_W  = 2;
   localparam logic [STATUS_W-1:0] ST_PINNED = 2'd0;
   localparam logic [STATUS_W-1:0] ST_CAND   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_MARKED = 2'd2;

   typedef enum logic [1:0] {
      OP_PIN,
      OP_UNPIN,
      OP_VICTIM,
      OP_NONE
   } op_type;

   typedef enum logic [2:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_RECOUNT,
      BK_EXEC,
      BK_SCAN
   } back_state_type;

   function automatic logic is_candidate(input logic [STATUS_W-1:0] status);
      return (status == ST_CAND) || (status == ST_MARKED);
   endfunction

endpackage

`default_nettype wire

// ----- design/crp_front.sv -----
// Request front end: accepts transactions and classifies them into commands.
`default_nettype none

module crp_front
   import crp_pkg::*;
#(
   parameter int FRAME_W = 6,
   parameter int COUNT_W = 7
) (
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   input  wire logic [MODE_W+FRAME_W-1:0] req_item,
   input  wire logic                      queue_full,
   input  wire logic                      init_busy,
   input  wire logic [COUNT_W-1:0]        active_frames,
   output logic                           push,
   output op_type                         push_op,
   output logic [FRAME_W-1:0]             push_idx
);

   logic [MODE_W-1:0] mode;
   logic              in_range;

   assign mode     = req_item[MODE_W-1:0];
   assign push_idx = req_item[MODE_W +: FRAME_W];
   assign in_range = COUNT_W'(push_idx) < active_frames;

   // pin or unpin of a frame outside the managed range changes no frame status
   always_comb begin
      unique case (mode)
         MODE_PIN:    push_op = in_range ? OP_PIN : OP_NONE;
         MODE_UNPIN:  push_op = in_range ? OP_UNPIN : OP_NONE;
         MODE_VICTIM: push_op = OP_VICTIM;
         default:     push_op = OP_NONE;
      endcase
   end

   assign req_tready = !queue_full && !init_busy;
   assign push       = req_tvalid && req_tready;

endmodule

`default_nettype wire

// ----- design/crp_queue.sv -----
// Short command queue between the front end and the replacement engine.
`default_nettype none

module crp_queue
   import crp_pkg::*;
#(
   parameter int FRAME_W = 6,
   parameter int DEPTH   = QUEUE_DEPTH
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire op_type             push_op,
   input  wire logic [FRAME_W-1:0] push_idx,
   output logic                    full,
   input  wire logic               pop,
   output logic                    out_valid,
   output op_type                  out_op,
   output logic [FRAME_W-1:0]      out_idx
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   op_type             op_ff  [DEPTH];
   logic [FRAME_W-1:0] idx_ff [DEPTH];
   logic [AW-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]      count_ff, count_in;

   assign full      = count_ff == CW'(DEPTH);
   assign out_valid = count_ff != '0;
   assign out_op    = op_ff[rd_ptr_ff];
   assign out_idx   = idx_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         op_ff[wr_ptr_ff]  <= push_op;
         idx_ff[wr_ptr_ff] <= push_idx;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("command queue holds more entries than its depth");

endmodule

`default_nettype wire

// ----- design/crp_back.sv -----
// Replacement engine: frame status memory, clock hand, candidate count and result register.
`default_nettype none

module crp_back
   import crp_pkg::*;
#(
   parameter int MAX_FRAMES = MAX_FRAMES_DEF,
   parameter int FRAME_W    = 6,
   parameter int COUNT_W    = 7
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic [COUNT_W-1:0] active_frames,
   input  wire logic [LIMIT_W-1:0] search_limit,
   input  wire logic               recount_req,
   output logic                    init_busy,
   input  wire logic               cmd_valid,
   input  wire op_type             cmd_op,
   input  wire logic [FRAME_W-1:0] cmd_idx,
   output logic                    cmd_pop,
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   output logic                    rsp_found,
   output logic [FRAME_W-1:0]      rsp_victim,
   output logic [COUNT_W-1:0]      rsp_count
);

   localparam logic [COUNT_W-1:0] LAST_FRAME = COUNT_W'(MAX_FRAMES - 1);

   back_state_type      state_ff, state_in;
   logic [FRAME_W-1:0]  hand_ff, hand_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [LIMIT_W-1:0]  rounds_ff, rounds_in;
   logic [COUNT_W-1:0]  addr_ff, addr_in;
   logic                pend_ff, pend_in;
   logic                dirty_ff, dirty_in;
   op_type              op_ff, op_in;
   logic [FRAME_W-1:0]  idx_ff, idx_in;

   logic                out_valid_ff, out_valid_in;
   logic                out_found_ff, out_found_in;
   logic [FRAME_W-1:0]  out_victim_ff, out_victim_in;
   logic [COUNT_W-1:0]  out_count_ff, out_count_in;

   logic [STATUS_W-1:0] status_mem [MAX_FRAMES];
   logic [STATUS_W-1:0] rd_data_ff;
   logic                byp_ff;
   logic [STATUS_W-1:0] byp_data_ff;

   logic                mem_we;
   logic [FRAME_W-1:0]  mem_waddr;
   logic [STATUS_W-1:0] mem_wdata;
   logic                mem_re;
   logic [FRAME_W-1:0]  mem_raddr;

   logic [STATUS_W-1:0] rd_status;
   logic                out_free;
   logic                out_load;
   logic                start_recount;
   logic [FRAME_W-1:0]  start_hand;
   logic [FRAME_W-1:0]  hand_next;
   logic [COUNT_W-1:0]  hand_inc;
   logic                limit_hit;

   // a read of the frame just written in the same cycle takes the new value
   assign rd_status = byp_ff ? byp_data_ff : rd_data_ff;
   assign out_free  = !out_valid_ff || rsp_tready;
   assign init_busy = state_ff == BK_CLEAR;

   assign start_hand = (COUNT_W'(hand_ff) >= active_frames) ? '0 : hand_ff;
   assign hand_inc   = COUNT_W'(hand_ff) + 1'b1;
   assign hand_next  = (hand_inc >= active_frames) ? '0 : hand_inc[FRAME_W-1:0];
   assign limit_hit  = ({1'b0, rounds_ff} + 1'b1) >= {1'b0, search_limit};

   always_comb begin
      state_in      = state_ff;
      hand_in       = hand_ff;
      count_in      = count_ff;
      rounds_in     = rounds_ff;
      addr_in       = addr_ff;
      pend_in       = pend_ff;
      op_in         = op_ff;
      idx_in        = idx_ff;
      out_valid_in  = out_valid_ff && !rsp_tready;
      out_found_in  = out_found_ff;
      out_victim_in = out_victim_ff;
      out_count_in  = out_count_ff;
      out_load      = 1'b0;
      start_recount = 1'b0;
      cmd_pop       = 1'b0;
      mem_we        = 1'b0;
      mem_waddr     = hand_ff;
      mem_wdata     = ST_PINNED;
      mem_re        = 1'b0;
      mem_raddr     = hand_ff;

      unique case (state_ff)
         BK_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = addr_ff[FRAME_W-1:0];
            mem_wdata = ST_PINNED;
            addr_in   = addr_ff + 1'b1;
            if (addr_ff == LAST_FRAME) begin
               addr_in  = '0;
               state_in = BK_IDLE;
            end
         end

         BK_IDLE: begin
            if (dirty_ff) begin
               start_recount = 1'b1;
               addr_in       = '0;
               pend_in       = 1'b0;
               count_in      = '0;
               state_in      = BK_RECOUNT;
            end else if (cmd_valid && out_free) begin
               cmd_pop = 1'b1;
               unique case (cmd_op) inside
                  OP_PIN, OP_UNPIN: begin
                     mem_re    = 1'b1;
                     mem_raddr = cmd_idx;
                     op_in     = cmd_op;
                     idx_in    = cmd_idx;
                     state_in  = BK_EXEC;
                  end
                  OP_VICTIM: begin
                     hand_in = start_hand;
                     if (search_limit == '0) begin
                        out_load      = 1'b1;
                        out_found_in  = 1'b0;
                        out_victim_in = '0;
                        out_count_in  = count_ff;
                     end else begin
                        mem_re    = 1'b1;
                        mem_raddr = start_hand;
                        rounds_in = '0;
                        state_in  = BK_SCAN;
                     end
                  end
                  default: begin
                     out_load      = 1'b1;
                     out_found_in  = 1'b0;
                     out_victim_in = '0;
                     out_count_in  = count_ff;
                  end
               endcase
            end
         end

         BK_RECOUNT: begin
            // stream reads over the managed frames, one per cycle
            if (pend_ff && is_candidate(rd_status)) begin
               count_in = count_ff + 1'b1;
            end
            if (addr_ff < active_frames) begin
               mem_re    = 1'b1;
               mem_raddr = addr_ff[FRAME_W-1:0];
               addr_in   = addr_ff + 1'b1;
               pend_in   = 1'b1;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  state_in = BK_IDLE;
               end
            end
         end

         BK_EXEC: begin
            mem_waddr = idx_ff;
            if (op_ff == OP_PIN) begin
               mem_we    = 1'b1;
               mem_wdata = ST_PINNED;
               if (is_candidate(rd_status)) begin
                  count_in = count_ff - 1'b1;
               end
            end else if (rd_status == ST_MARKED) begin
               mem_we    = 1'b1;
               mem_wdata = ST_CAND;
            end else if (rd_status != ST_CAND) begin
               mem_we    = 1'b1;
               mem_wdata = ST_MARKED;
               count_in  = count_ff + 1'b1;
            end
            out_load      = 1'b1;
            out_found_in  = 1'b0;
            out_victim_in = '0;
            out_count_in  = count_in;
            state_in      = BK_IDLE;
         end

         BK_SCAN: begin
            mem_waddr = hand_ff;
            if (rd_status == ST_CAND) begin
               mem_we        = 1'b1;
               mem_wdata     = ST_PINNED;
               count_in      = count_ff - 1'b1;
               hand_in       = hand_next;
               out_load      = 1'b1;
               out_found_in  = 1'b1;
               out_victim_in = hand_ff;
               out_count_in  = count_in;
               state_in      = BK_IDLE;
            end else begin
               if (rd_status == ST_MARKED) begin
                  mem_we    = 1'b1;
                  mem_wdata = ST_CAND;
               end
               if (limit_hit) begin
                  // give up, hand stays on the last frame inspected
                  out_load      = 1'b1;
                  out_found_in  = 1'b0;
                  out_victim_in = '0;
                  out_count_in  = count_ff;
                  state_in      = BK_IDLE;
               end else begin
                  hand_in   = hand_next;
                  mem_re    = 1'b1;
                  mem_raddr = hand_next;
                  rounds_in = rounds_ff + 1'b1;
               end
            end
         end

         default: state_in = BK_IDLE;
      endcase

      if (out_load) begin
         out_valid_in = 1'b1;
      end
      dirty_in = recount_req || (dirty_ff && !start_recount);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_CLEAR;
         hand_ff      <= '0;
         count_ff     <= '0;
         addr_ff      <= '0;
         pend_ff      <= 1'b0;
         dirty_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
         byp_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hand_ff      <= hand_in;
         count_ff     <= count_in;
         addr_ff      <= addr_in;
         pend_ff      <= pend_in;
         dirty_ff     <= dirty_in;
         out_valid_ff <= out_valid_in;
         byp_ff       <= mem_we && mem_re && (mem_waddr == mem_raddr);
      end
   end

   always_ff @(posedge clock) begin
      rounds_ff     <= rounds_in;
      op_ff         <= op_in;
      idx_ff        <= idx_in;
      out_found_ff  <= out_found_in;
      out_victim_ff <= out_victim_in;
      out_count_ff  <= out_count_in;
      byp_data_ff   <= mem_wdata;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         status_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= status_mem[mem_raddr];
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_found  = out_found_ff;
   assign rsp_victim = out_victim_ff;
   assign rsp_count  = out_count_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_load |-> (!out_valid_ff || rsp_tready))
      else $error("result loaded over a transaction not yet taken");

   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_CLEAR) |-> (!cmd_pop && !out_load))
      else $error("command handled during the clearing pass");

   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> cmd_valid)
      else $error("command popped from an empty queue");

endmodule

`default_nettype wire

// ----- design/clock_page_replacer.sv -----
// Top level of the clock page replacer: ports, configuration registers and wiring.
// Clock replacement over MAX_FRAMES buffer frames. Each request transaction pins a frame,
// unpins it, or asks for a victim; every request returns exactly one response with the
// candidate count. A request is classified on entry and queued (two entries), so
// requests are taken while the engine works and while a response waits, until the queue
// is full. The engine answers an unused mode or an out-of-range frame without touching
// the status memory, reads and then writes the status memory for pin or unpin, and in a
// victim search inspects at most search_limit frames, one frame per cycle through the
// single read port of the status memory. After reset a clearing pass writes every frame
// pinned, during which req_tready is low. A write of frames_in_use makes the engine
// recount candidates over the new range before the next request.
`default_nettype none

module clock_page_replacer
   import crp_pkg::*;
#(
   parameter int MAX_FRAMES = MAX_FRAMES_DEF,
   localparam int FRAME_W   = $clog2(MAX_FRAMES),
   localparam int COUNT_W   = $clog2(MAX_FRAMES + 1),
   localparam int ITEM_W    = MODE_W + FRAME_W,
   localparam int REQ_W     = ((ITEM_W + 7) / 8) * 8,
   localparam int RSP_ITEM_W = 1 + FRAME_W + COUNT_W,
   localparam int RSP_W     = ((RSP_ITEM_W + 7) / 8) * 8,
   localparam int CSR_W     = (FRAMES_REG_W > LIMIT_W) ? FRAMES_REG_W : LIMIT_W
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_W-1:0]      req_tdata,   // mode, frame_index
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_W-1:0]           rsp_tdata,   // found, victim_frame, candidate_count
   input  wire logic                  csr_wen,
   input  wire logic [CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [CSR_W-1:0]      csr_wdata
);

   logic [FRAMES_REG_W-1:0] frames_in_use_ff;
   logic [LIMIT_W-1:0] search_limit_ff;
   logic [COUNT_W-1:0] active_frames;
   logic               recount_req;

   logic               queue_full;
   logic               init_busy;
   logic               push;
   op_type             push_op;
   logic [FRAME_W-1:0] push_idx;
   logic               cmd_valid;
   op_type             cmd_op;
   logic [FRAME_W-1:0] cmd_idx;
   logic               cmd_pop;
   logic               rsp_found;
   logic [FRAME_W-1:0] rsp_victim;
   logic [COUNT_W-1:0] rsp_count;

   always_ff @(posedge clock) begin
      if (reset) begin
         frames_in_use_ff <= FRAMES_REG_W'(FRAMES_RESET);
         search_limit_ff  <= LIMIT_RESET;
      end else if (csr_wen) begin
         case (csr_addr)
            CSR_FRAMES_IN_USE: frames_in_use_ff <= csr_wdata[FRAMES_REG_W-1:0];
            CSR_SEARCH_LIMIT:  search_limit_ff  <= csr_wdata[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   // zero frames acts as one, anything above the array acts as the full array
   always_comb begin
      if (frames_in_use_ff == '0) begin
         active_frames = COUNT_W'(1);
      end else if (int'(frames_in_use_ff) > MAX_FRAMES) begin
         active_frames = COUNT_W'(MAX_FRAMES);
      end else begin
         active_frames = COUNT_W'(frames_in_use_ff);
      end
   end

   assign recount_req = csr_wen && (csr_addr == CSR_FRAMES_IN_USE);

   crp_front #(
      .FRAME_W (FRAME_W),
      .COUNT_W (COUNT_W)
   ) u_front (
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_item      (req_tdata[ITEM_W-1:0]),
      .queue_full    (queue_full),
      .init_busy     (init_busy),
      .active_frames (active_frames),
      .push          (push),
      .push_op       (push_op),
      .push_idx      (push_idx)
   );

   crp_queue #(
      .FRAME_W (FRAME_W),
      .DEPTH   (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_op   (push_op),
      .push_idx  (push_idx),
      .full      (queue_full),
      .pop       (cmd_pop),
      .out_valid (cmd_valid),
      .out_op    (cmd_op),
      .out_idx   (cmd_idx)
   );

   crp_back #(
      .MAX_FRAMES (MAX_FRAMES),
      .FRAME_W    (FRAME_W),
      .COUNT_W    (COUNT_W)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .active_frames (active_frames),
      .search_limit  (search_limit_ff),
      .recount_req   (recount_req),
      .init_busy     (init_busy),
      .cmd_valid     (cmd_valid),
      .cmd_op        (cmd_op),
      .cmd_idx       (cmd_idx),
      .cmd_pop       (cmd_pop),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_found     (rsp_found),
      .rsp_victim    (rsp_victim),
      .rsp_count     (rsp_count)
   );

   assign rsp_tdata = RSP_W'({rsp_count, rsp_victim, rsp_found});

endmodule

`default_nettype wire
